[src/ppc_pkg.sv]
// -----------------------------------------------------------------------------
// ppc_pkg: shared constants for planar pose compounding
// Default parameter values, CORDIC word width, angle constants in Q2.30 and
// the arctangent table of the rotation cells.
// -----------------------------------------------------------------------------
package ppc_pkg;

  localparam int POS_BITS_DEF   = 32;
  localparam int ANGLE_BITS_DEF = 16;

  // CORDIC datapath: Q2.30 words with headroom for +-4 rad and gain growth
  localparam int CORDIC_STEPS = 30;
  localparam int ZW           = 34;

  localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sh0_6487_ED51;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sh0_C90F_DAA2;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input int unsigned step);
    logic [31:0] v;
    case (step)
      0:       v = 32'h3243_F6A8;
      1:       v = 32'h1DAC_6705;
      2:       v = 32'h0FAD_BAFC;
      3:       v = 32'h07F5_6EA6;
      4:       v = 32'h03FE_AB76;
      5:       v = 32'h01FF_D55B;
      6:       v = 32'h00FF_FAAA;
      7:       v = 32'h007F_FF55;
      8:       v = 32'h003F_FFEA;
      9:       v = 32'h001F_FFFD;
      10:      v = 32'h000F_FFFF;
      11:      v = 32'h0007_FFFF;
      12:      v = 32'h0003_FFFF;
      13:      v = 32'h0001_FFFF;
      14:      v = 32'h0000_FFFF;
      15:      v = 32'h0000_7FFF;
      16:      v = 32'h0000_3FFF;
      17:      v = 32'h0000_1FFF;
      18:      v = 32'h0000_0FFF;
      19:      v = 32'h0000_07FF;
      20:      v = 32'h0000_03FF;
      21:      v = 32'h0000_01FF;
      22:      v = 32'h0000_00FF;
      23:      v = 32'h0000_007F;
      24:      v = 32'h0000_003F;
      25:      v = 32'h0000_001F;
      26:      v = 32'h0000_000F;
      27:      v = 32'h0000_0008;
      28:      v = 32'h0000_0004;
      29:      v = 32'h0000_0002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/planar_pose_compounding.sv]
// -----------------------------------------------------------------------------
// planar_pose_compounding: SE(2) pose compounding with heading Jacobian
// Rotates a body-frame motion by the pose heading through a chain of CORDIC
// cells, adds it to the position, wraps the heading and returns the two
// heading columns of the state Jacobian.
// -----------------------------------------------------------------------------
// One transaction in gives one transaction out. While the output is not
// stalled, the block takes a new pose every clock cycle and holds a
// throughput of one transaction per cycle. From input acceptance to the
// output a transaction passes one front stage (quadrant fold and heading
// wrap), 30 CORDIC cells (one micro-rotation each) and four output stages
// (trig rounding, products, sums, add and saturate). Every stage is elastic:
// a stalled output only stops stages that are full, so bubbles are squeezed
// out and the input keeps being taken while results wait. Positions are
// signed Q(POS_BITS-16).16 and saturate; angles are signed Q3.(ANGLE_BITS-3)
// radians, any input pattern (up to +-4 rad) is accepted, and next_heading
// lands in (-pi, pi]. tdata fields are packed from bit 0 upward without gaps
// and zero padded to whole bytes.
// -----------------------------------------------------------------------------
module planar_pose_compounding #(
  parameter int POS_BITS   = ppc_pkg::POS_BITS_DEF,
  parameter int ANGLE_BITS = ppc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // pose_x, pose_y, pose_heading, move_forward, move_lateral, move_turn
  input  logic [((4*POS_BITS+2*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // next_x, next_y, next_heading, jac_x_by_heading, jac_y_by_heading
  output logic [((4*POS_BITS+ANGLE_BITS+7)/8)*8-1:0]   out_tdata
);

  localparam int P     = POS_BITS;
  localparam int A     = ANGLE_BITS;
  localparam int ZW    = ppc_pkg::ZW;
  localparam int N     = ppc_pkg::CORDIC_STEPS;
  localparam int OUT_W = ((4*P+A+7)/8)*8;
  localparam int SB_W  = 4*P + A + 1;
  localparam int HW    = A + 2;
  localparam int ZSH   = 33 - A;  // Q3.(A-3) to Q2.30

  // pi rounded half up to the angle format
  localparam longint PI_A_L =
    (longint'(ppc_pkg::PI_Q30) + ((longint'(1) << ZSH) >> 1)) >>> ZSH;
  localparam logic signed [HW-1:0] PI_A     = HW'(PI_A_L);
  localparam logic signed [HW-1:0] TWO_PI_A = HW'(2 * PI_A_L);

  // input field unpack
  logic signed [P-1:0] in_px, in_py, in_fw, in_lt;
  logic signed [A-1:0] in_hd, in_tn;

  assign in_px = in_tdata[P-1:0];
  assign in_py = in_tdata[2*P-1:P];
  assign in_hd = in_tdata[2*P+A-1:2*P];
  assign in_fw = in_tdata[3*P+A-1:2*P+A];
  assign in_lt = in_tdata[4*P+A-1:3*P+A];
  assign in_tn = in_tdata[4*P+2*A-1:4*P+A];

  // front stage: fold the heading into +-pi/2, wrap heading + turn
  logic signed [ZW-1:0] z_raw, z_nxt;
  logic                 flip_nxt;
  logic signed [HW-1:0] h0, h1, h2, h3, h4;

  assign z_raw = ZW'(in_hd) <<< ZSH;

  always_comb begin
    if (z_raw > ppc_pkg::HALF_PI_Q30) begin
      z_nxt    = z_raw - ppc_pkg::PI_Q30;
      flip_nxt = 1'b1;
    end else if (z_raw < -ppc_pkg::HALF_PI_Q30) begin
      z_nxt    = z_raw + ppc_pkg::PI_Q30;
      flip_nxt = 1'b1;
    end else begin
      z_nxt    = z_raw;
      flip_nxt = 1'b0;
    end
  end

  assign h0 = HW'(in_hd) + HW'(in_tn);
  assign h1 = (h0 > PI_A) ? h0 - TWO_PI_A : h0;
  assign h2 = (h1 > PI_A) ? h1 - TWO_PI_A : h1;
  assign h3 = (h2 <= -PI_A) ? h2 + TWO_PI_A : h2;
  assign h4 = (h3 <= -PI_A) ? h3 + TWO_PI_A : h3;

  // CORDIC chain links; index k feeds cell k
  logic                 ch_valid [0:N];
  logic                 ch_ready [0:N];
  logic signed [ZW-1:0] ch_x     [0:N];
  logic signed [ZW-1:0] ch_y     [0:N];
  logic signed [ZW-1:0] ch_z     [0:N];
  logic [SB_W-1:0]      ch_sb    [0:N];

  logic                 front_valid_r;
  logic signed [ZW-1:0] front_z_r;
  logic [SB_W-1:0]      front_sb_r;

  assign in_tready = !front_valid_r || ch_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_tready) begin
      front_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      front_z_r  <= z_nxt;
      front_sb_r <= {flip_nxt, h4[A-1:0], in_lt, in_fw, in_py, in_px};
    end
  end

  assign ch_valid[0] = front_valid_r;
  assign ch_x[0]     = ppc_pkg::CORDIC_GAIN;
  assign ch_y[0]     = '0;
  assign ch_z[0]     = front_z_r;
  assign ch_sb[0]    = front_sb_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    ppc_cordic_cell #(
      .STEP (k),
      .SB_W (SB_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[k]),
      .up_ready (ch_ready[k]),
      .up_x     (ch_x[k]),
      .up_y     (ch_y[k]),
      .up_z     (ch_z[k]),
      .up_sb    (ch_sb[k]),
      .dn_valid (ch_valid[k+1]),
      .dn_ready (ch_ready[k+1]),
      .dn_x     (ch_x[k+1]),
      .dn_y     (ch_y[k+1]),
      .dn_z     (ch_z[k+1]),
      .dn_sb    (ch_sb[k+1])
    );
  end

  // residual angle of the last cell is not needed
  logic [P-1:0] nx, ny, jx, jy;
  logic [A-1:0] nh;

  ppc_rot_out #(
    .POS_BITS   (P),
    .ANGLE_BITS (A)
  ) u_rot_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (ch_valid[N]),
    .up_ready         (ch_ready[N]),
    .up_x             (ch_x[N]),
    .up_y             (ch_y[N]),
    .up_sb            (ch_sb[N]),
    .dn_valid         (out_tvalid),
    .dn_ready         (out_tready),
    .next_x           (nx),
    .next_y           (ny),
    .next_heading     (nh),
    .jac_x_by_heading (jx),
    .jac_y_by_heading (jy)
  );

  assign out_tdata = OUT_W'({jy, jx, nh, ny, nx});

endmodule

[src/ppc_cordic_cell.sv]
// -----------------------------------------------------------------------------
// ppc_cordic_cell: one CORDIC rotation step
// Registered micro-rotation by atan(2^-STEP) with a sideband payload that
// travels alongside; elastic valid/ready stage.
// -----------------------------------------------------------------------------
module ppc_cordic_cell #(
  parameter int STEP = 0,
  parameter int SB_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [ppc_pkg::ZW-1:0] up_x,
  input  logic signed [ppc_pkg::ZW-1:0] up_y,
  input  logic signed [ppc_pkg::ZW-1:0] up_z,
  input  logic [SB_W-1:0]               up_sb,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [ppc_pkg::ZW-1:0] dn_x,
  output logic signed [ppc_pkg::ZW-1:0] dn_y,
  output logic signed [ppc_pkg::ZW-1:0] dn_z,
  output logic [SB_W-1:0]               dn_sb
);

  localparam logic signed [ppc_pkg::ZW-1:0] ATAN =
    ppc_pkg::ZW'(ppc_pkg::atan_q30(STEP));

  logic                          valid_r;
  logic signed [ppc_pkg::ZW-1:0] x_r, y_r, z_r;
  logic signed [ppc_pkg::ZW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [ppc_pkg::ZW-1:0] xs, ys;
  logic [SB_W-1:0]               sb_r;

  assign up_ready = !valid_r || dn_ready;

  assign xs = up_x >>> STEP;
  assign ys = up_y >>> STEP;

  // rotate toward z = 0
  always_comb begin
    if (!up_z[ppc_pkg::ZW-1]) begin
      x_nxt = up_x - ys;
      y_nxt = up_y + xs;
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + ys;
      y_nxt = up_y - xs;
      z_nxt = up_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      sb_r <= up_sb;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;
  assign dn_sb    = sb_r;

endmodule

[src/ppc_rot_out.sv]
// -----------------------------------------------------------------------------
// ppc_rot_out: rotate the motion and compound the pose
// Four elastic stages: trig rounding and quadrant sign, four products,
// product sums with rounding to Q16.16, final add and saturation.
// -----------------------------------------------------------------------------
module ppc_rot_out #(
  parameter int POS_BITS   = ppc_pkg::POS_BITS_DEF,
  parameter int ANGLE_BITS = ppc_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [ppc_pkg::ZW-1:0] up_x,
  input  logic signed [ppc_pkg::ZW-1:0] up_y,
  input  logic [4*POS_BITS+ANGLE_BITS:0] up_sb,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [POS_BITS-1:0]           next_x,
  output logic [POS_BITS-1:0]           next_y,
  output logic [ANGLE_BITS-1:0]         next_heading,
  output logic [POS_BITS-1:0]           jac_x_by_heading,
  output logic [POS_BITS-1:0]           jac_y_by_heading
);

  localparam int P    = POS_BITS;
  localparam int A    = ANGLE_BITS;
  localparam int ZW   = ppc_pkg::ZW;
  localparam int T    = ((60 - P) < 30) ? (60 - P) : 30;  // trig fraction bits
  localparam int CT   = T + 2;
  localparam int PW   = CT + P;
  localparam int RSH  = 30 - T;
  localparam int DW   = P + 3;
  localparam int SW   = P + 4;

  localparam logic signed [ZW-1:0] RND_C = ZW'((longint'(1) << RSH) >> 1);
  localparam logic signed [PW:0]   RND_T = (PW+1)'((longint'(1) << T) >> 1);
  localparam logic signed [SW-1:0] MAXV  = SW'((longint'(1) << (P - 1)) - 1);
  localparam logic signed [SW-1:0] MINV  = -MAXV - SW'(1);

  function automatic logic [P-1:0] sat_p(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > MAXV) begin
      r = MAXV;
    end else if (v < MINV) begin
      r = MINV;
    end else begin
      r = v;
    end
    return r[P-1:0];
  endfunction

  // stage handshake
  logic [3:0] v_r;
  logic [3:0] rdy;

  assign rdy[3]   = !v_r[3] || dn_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  // sideband unpack
  logic signed [P-1:0] sb_px, sb_py, sb_fw, sb_lt;
  logic [A-1:0]        sb_hd;
  logic                sb_flip;

  assign sb_px   = up_sb[P-1:0];
  assign sb_py   = up_sb[2*P-1:P];
  assign sb_fw   = up_sb[3*P-1:2*P];
  assign sb_lt   = up_sb[4*P-1:3*P];
  assign sb_hd   = up_sb[4*P+A-1:4*P];
  assign sb_flip = up_sb[4*P+A];

  // stage 0: quadrant sign and rounding of cos/sin to T fraction bits
  logic signed [ZW-1:0] xf, yf;
  logic signed [CT-1:0] c_nxt, s_nxt;
  logic signed [CT-1:0] c_r, s_r;
  logic signed [P-1:0]  px0_r, py0_r, fw0_r, lt0_r;
  logic [A-1:0]         hd0_r;

  assign xf    = sb_flip ? -up_x : up_x;
  assign yf    = sb_flip ? -up_y : up_y;
  assign c_nxt = CT'((xf + RND_C) >>> RSH);
  assign s_nxt = CT'((yf + RND_C) >>> RSH);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      px0_r <= sb_px;
      py0_r <= sb_py;
      fw0_r <= sb_fw;
      lt0_r <= sb_lt;
      hd0_r <= sb_hd;
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p_cf_r, p_sl_r, p_sf_r, p_cl_r;
  logic signed [P-1:0]  px1_r, py1_r;
  logic [A-1:0]         hd1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_cf_r <= PW'(c_r) * PW'(fw0_r);
      p_sl_r <= PW'(s_r) * PW'(lt0_r);
      p_sf_r <= PW'(s_r) * PW'(fw0_r);
      p_cl_r <= PW'(c_r) * PW'(lt0_r);
      px1_r  <= px0_r;
      py1_r  <= py0_r;
      hd1_r  <= hd0_r;
    end
  end

  // stage 2: rotated motion, rounded half up to Q16.16
  logic signed [PW:0]   sum_x, sum_y;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [P-1:0]  px2_r, py2_r;
  logic [A-1:0]         hd2_r;

  assign sum_x = (PW+1)'(p_cf_r) - (PW+1)'(p_sl_r) + RND_T;
  assign sum_y = (PW+1)'(p_sf_r) + (PW+1)'(p_cl_r) + RND_T;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dx_r  <= DW'(sum_x >>> T);
      dy_r  <= DW'(sum_y >>> T);
      px2_r <= px1_r;
      py2_r <= py1_r;
      hd2_r <= hd1_r;
    end
  end

  // stage 3: position update, Jacobian entries, saturation
  logic [P-1:0] nx_r, ny_r, jx_r, jy_r;
  logic [A-1:0] hd3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      nx_r  <= sat_p(SW'(px2_r) + SW'(dx_r));
      ny_r  <= sat_p(SW'(py2_r) + SW'(dy_r));
      jx_r  <= sat_p(-SW'(dy_r));
      jy_r  <= sat_p(SW'(dx_r));
      hd3_r <= hd2_r;
    end
  end

  assign next_x           = nx_r;
  assign next_y           = ny_r;
  assign next_heading     = hd3_r;
  assign jac_x_by_heading = jx_r;
  assign jac_y_by_heading = jy_r;

endmodule

[tb/planar_pose_compounding_tb.sv]
// -----------------------------------------------------------------------------
// planar_pose_compounding_tb: self-checking bench for planar pose compounding
// Drives pose/motion transactions on the input stream and checks every result
// transaction against a bit-accurate in-bench predictor: a 30-step CORDIC
// rotation, rounding, saturating adds and heading wrap. Covers directed
// corners, random traffic under three idle mixes, a long output hold-off and
// a full drain pause.
// -----------------------------------------------------------------------------
module planar_pose_compounding_tb;

  localparam int POS_W = ppc_pkg::POS_BITS_DEF;
  localparam int ANG_W = ppc_pkg::ANGLE_BITS_DEF;
  localparam int IN_W  = ((4*POS_W + 2*ANG_W + 7) / 8) * 8;
  localparam int OUT_W = ((4*POS_W + ANG_W + 7) / 8) * 8;

  // angle and trig formats
  localparam int ANG_FRAC   = ANG_W - 3;
  localparam int TRIG_FRAC  = ((60 - POS_W) < 30) ? (60 - POS_W) : 30;
  localparam int ROT_STEPS  = 30;
  localparam int HEADING_PI = 25736;           // round(pi * 2^13)
  localparam int QUARTER_PI = 6434;

  localparam longint ROT_GAIN_Q30 = 64'h0000_0000_26DD_3B6A;
  localparam longint HALF_PI_Z    = 64'h0000_0000_6487_ED51;
  localparam longint PI_Z         = 64'h0000_0000_C90F_DAA2;

  localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));

  localparam logic signed [POS_W-1:0] P_MAX = POS_HI[POS_W-1:0];
  localparam logic signed [POS_W-1:0] P_MIN = POS_LO[POS_W-1:0];
  localparam logic signed [POS_W-1:0] P_ONE = 32'sh0001_0000;

  // no input accepted and no result taken for this many cycles means a hang;
  // random stalls at 76% practically never come near it and the long hold-off
  // stays well below it
  localparam int HANG_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 45;            // exceeds the pipeline depth
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] heading;
    logic signed [POS_W-1:0] fwd;
    logic signed [POS_W-1:0] lat;
    logic signed [ANG_W-1:0] turn;
  } pose_move_t;

  typedef struct {
    logic signed [POS_W-1:0] next_x;
    logic signed [POS_W-1:0] next_y;
    logic signed [ANG_W-1:0] next_heading;
    logic signed [POS_W-1:0] jac_x;
    logic signed [POS_W-1:0] jac_y;
  } pose_update_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  pose_update_t expected_updates[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;   // forced receiver hold-off, in cycles
  int mismatches     = 0;
  int poses_sent     = 0;
  int updates_seen   = 0;
  int quiet_cycles   = 0;

  planar_pose_compounding #(
    .POS_BITS  (POS_W),
    .ANGLE_BITS(ANG_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i), Q2.30
  function automatic longint arctan_q30(input int i);
    case (i)
      0:  return 64'h3243F6A8;  1:  return 64'h1DAC6705;  2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;  4:  return 64'h03FEAB76;  5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;  7:  return 64'h007FFF55;  8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;  10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;  13: return 64'h0001FFFF;  14: return 64'h0000FFFF;
      15: return 64'h00007FFF;  16: return 64'h00003FFF;  17: return 64'h00001FFF;
      18: return 64'h00000FFF;  19: return 64'h000007FF;  20: return 64'h000003FF;
      21: return 64'h000001FF;  22: return 64'h000000FF;  23: return 64'h0000007F;
      24: return 64'h0000003F;  25: return 64'h0000001F;  26: return 64'h0000000F;
      27: return 64'h00000008;  28: return 64'h00000004;  29: return 64'h00000002;
      default: return 64'h0;
    endcase
  endfunction

  // round half up, drop n fraction bits (floor shift)
  function automatic longint round_off(input longint v, input int n);
    if (n == 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > POS_HI) return P_MAX;
    if (v < POS_LO) return P_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic pose_update_t compound_pose(input pose_move_t m);
    pose_update_t r;
    longint z, cs, sn, xs, ys, dx, dy;
    int     h;
    bit     flip;
    z    = longint'(m.heading) <<< (30 - ANG_FRAC);
    cs   = ROT_GAIN_Q30;
    sn   = 0;
    flip = 1'b0;
    // fold into +-pi/2 so the rotation converges, undo by negation afterwards
    if (z > HALF_PI_Z) begin
      z    = z - PI_Z;
      flip = 1'b1;
    end else if (z < -HALF_PI_Z) begin
      z    = z + PI_Z;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = cs >>> i;
      ys = sn >>> i;
      if (z >= 0) begin
        cs = cs - ys;
        sn = sn + xs;
        z  = z - arctan_q30(i);
      end else begin
        cs = cs + ys;
        sn = sn - xs;
        z  = z + arctan_q30(i);
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    cs = round_off(cs, 30 - TRIG_FRAC);
    sn = round_off(sn, 30 - TRIG_FRAC);
    dx = round_off(cs * longint'(m.fwd) - sn * longint'(m.lat), TRIG_FRAC);
    dy = round_off(sn * longint'(m.fwd) + cs * longint'(m.lat), TRIG_FRAC);

    // wrap heading into (-pi, pi]
    h = int'(m.heading) + int'(m.turn);
    while (h > HEADING_PI) h = h - 2 * HEADING_PI;
    while (h <= -HEADING_PI) h = h + 2 * HEADING_PI;

    r.next_x       = clamp_pos(longint'(m.x) + dx);
    r.next_y       = clamp_pos(longint'(m.y) + dy);
    r.next_heading = h[ANG_W-1:0];
    r.jac_x        = clamp_pos(-dy);
    r.jac_y        = clamp_pos(dx);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pose_move_t make_pose(
    input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
    input logic signed [ANG_W-1:0] h, input logic signed [POS_W-1:0] f,
    input logic signed [POS_W-1:0] l, input logic signed [ANG_W-1:0] t);
    pose_move_t m;
    m.x = x; m.y = y; m.heading = h; m.fwd = f; m.lat = l; m.turn = t;
    return m;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_corner();
    case ($urandom_range(4))
      0:       return P_MAX;
      1:       return P_MIN;
      2:       return '0;
      3:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic pose_move_t random_pose();
    pose_move_t m;
    int         kind;
    kind = $urandom_range(9);
    m.x  = $urandom;
    m.y  = $urandom;
    case (kind)
      0: begin
        // any bit pattern, heading up to +-4 rad
        m.heading = ANG_W'($urandom);
        m.turn    = ANG_W'($urandom);
        m.fwd     = $urandom;
        m.lat     = $urandom;
      end
      1: begin
        m.x       = pick_corner();
        m.y       = pick_corner();
        m.fwd     = pick_corner();
        m.lat     = pick_corner();
        m.heading = ($urandom_range(1)) ? ANG_W'(HEADING_PI) : ANG_W'(-HEADING_PI);
        m.turn    = ANG_W'(int'($urandom_range(2 * HEADING_PI)) - HEADING_PI);
      end
      default: begin
        // ordinary odometry step: in-range angles, motion of random magnitude
        m.heading = ANG_W'(int'($urandom_range(2 * HEADING_PI)) - HEADING_PI);
        m.turn    = ANG_W'(int'($urandom_range(2 * HEADING_PI)) - HEADING_PI);
        m.fwd     = $signed($urandom) >>> $urandom_range(31);
        m.lat     = $signed($urandom) >>> $urandom_range(31);
      end
    endcase
    return m;
  endfunction

  // Offer one transaction, wait for acceptance, then queue its expected result.
  // tvalid stays high after acceptance; only an idle cycle or a drain wait lowers it.
  task automatic send_pose(input pose_move_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {m.turn, m.lat, m.fwd, m.heading, m.y, m.x};
    do @(posedge clk); while (!in_tready);
    expected_updates.push_back(compound_pose(m));
    poses_sent++;
  endtask

  task automatic set_idle_mix(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    // plain moves and the fold boundary around +-pi/2
    send_pose(make_pose('0, '0, '0, '0, '0, '0));
    send_pose(make_pose(P_ONE, -P_ONE, '0, P_ONE, '0, '0));
    send_pose(make_pose('0, '0, 16'sd12867, P_ONE, P_ONE, '0));
    send_pose(make_pose('0, '0, 16'sd12868, P_ONE, P_ONE, '0));
    send_pose(make_pose('0, '0, -16'sd12867, P_ONE, -P_ONE, '0));
    send_pose(make_pose('0, '0, -16'sd12868, P_ONE, -P_ONE, '0));
    // heading wrap, both edges of (-pi, pi]
    send_pose(make_pose(P_ONE, P_ONE, ANG_W'(HEADING_PI), P_ONE, '0, '0));
    send_pose(make_pose(P_ONE, P_ONE, ANG_W'(-HEADING_PI), P_ONE, '0, '0));
    send_pose(make_pose('0, '0, ANG_W'(HEADING_PI), P_ONE, '0, ANG_W'(HEADING_PI)));
    send_pose(make_pose('0, '0, ANG_W'(-HEADING_PI), P_ONE, '0, ANG_W'(-HEADING_PI)));
    send_pose(make_pose('0, '0, ANG_W'(HEADING_PI), '0, P_ONE, 16'sd1));
    // heading outside +-pi, full 16-bit extremes
    send_pose(make_pose('0, '0, 16'sh7FFF, P_ONE, P_ONE, 16'sh7FFF));
    send_pose(make_pose('0, '0, 16'sh8000, P_ONE, P_ONE, 16'sh8000));
    send_pose(make_pose(P_ONE, P_ONE, 16'sh8000, P_MAX, P_MIN, '0));
    // position and Jacobian saturation
    send_pose(make_pose(P_MAX, '0, '0, P_MAX, '0, '0));
    send_pose(make_pose(P_MIN, '0, '0, P_MIN, '0, '0));
    send_pose(make_pose('0, P_MAX, '0, '0, P_MAX, '0));
    send_pose(make_pose('0, '0, '0, '0, P_MIN, '0));
    send_pose(make_pose(P_MIN, P_MIN, ANG_W'(QUARTER_PI), P_MIN, P_MIN, '0));
    send_pose(make_pose(P_MAX, P_MAX, ANG_W'(HEADING_PI), P_MAX, P_MAX,
                        ANG_W'(HEADING_PI)));
    send_pose(make_pose(P_MIN, P_MIN, ANG_W'(-HEADING_PI), P_MIN, P_MIN,
                        ANG_W'(-HEADING_PI)));
    // single-LSB motion: rounding
    send_pose(make_pose(-32'sd1, 32'sd1, 16'sd3000, 32'sd1, -32'sd1, -16'sd3000));
    send_pose(make_pose('0, '0, 16'sd1, P_MAX, P_MAX, -16'sd1));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_pose(random_pose());
  endtask

  // receiver holds off long enough for the pipeline to fill and push back
  task automatic test_output_hold_off();
    hold_left = 200;
    repeat (120) send_pose(random_pose());
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (20) send_pose(random_pose());
    wait_drained();
    repeat (20) send_pose(random_pose());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pose_update_t e;
    pose_update_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.next_x       = out_tdata[31:0];
      g.next_y       = out_tdata[63:32];
      g.next_heading = out_tdata[79:64];
      g.jac_x        = out_tdata[111:80];
      g.jac_y        = out_tdata[143:112];
      updates_seen++;
      if (expected_updates.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        e = expected_updates.pop_front();
        if (g.next_x !== e.next_x)
          report_mismatch($sformatf("next_x got %0d exp %0d", g.next_x, e.next_x));
        if (g.next_y !== e.next_y)
          report_mismatch($sformatf("next_y got %0d exp %0d", g.next_y, e.next_y));
        if (g.next_heading !== e.next_heading)
          report_mismatch($sformatf("next_heading got %0d exp %0d",
                                    g.next_heading, e.next_heading));
        if (g.jac_x !== e.jac_x)
          report_mismatch($sformatf("jac_x_by_heading got %0d exp %0d", g.jac_x, e.jac_x));
        if (g.jac_y !== e.jac_y)
          report_mismatch($sformatf("jac_y_by_heading got %0d exp %0d", g.jac_y, e.jac_y));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
      $display("FAIL planar_pose_compounding");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_idle_mix(30, 76);
    test_directed_cases();
    test_random_traffic(430);
    set_idle_mix(76, 30);
    test_random_traffic(430);
    set_idle_mix(0, 0);
    test_random_traffic(430);
    test_output_hold_off();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_updates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_updates.size()));

    $display("covered %0d pose updates: corners, wraps, saturation, three idle mixes",
             poses_sent);
    $display("plus a long output hold-off and a drain pause; %0d results, %0d mismatches",
             updates_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS planar_pose_compounding");
    end else begin
      $display("FAIL planar_pose_compounding");
    end
    $finish;
  end

endmodule

[sim.f]
src/ppc_pkg.sv
src/ppc_cordic_cell.sv
src/ppc_rot_out.sv
src/planar_pose_compounding.sv
tb/planar_pose_compounding_tb.sv
